// ===== hdl/stf_pwm_pkg.sv =====
// Shared constants for the servo target filter and PWM duty mapper.
// Fixed field widths, angle scale, reset values and register indexes.
// No dependencies.
package stf_pwm_pkg;

  localparam int ANGLE_W = 14;   // angles in 1/64 degree
  localparam int PULSE_W = 15;   // pulse widths in microseconds
  localparam int CMD_W   = 16;   // signed command value

  localparam logic [ANGLE_W-1:0] FULL_ANGLE = 14'd11520;  // 180 degrees
  localparam logic [ANGLE_W-1:0] HOME_ANGLE = 14'd5760;   // 90 degrees
  localparam logic [PULSE_W-1:0] NORM_FULL  = 15'd16384;  // full span of a position

  localparam logic [2:0] FILTER_DIV = 3'd5;  // smoothing moves 1/5 of the way

  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 15'd1050;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 15'd1950;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_MIN_PULSE = 2'd1;
  localparam logic [1:0] REG_MAX_PULSE = 2'd2;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

endpackage

// ===== hdl/servo_target_filter_to_pwm_duty.sv =====
// Servo command filter and PWM duty mapper, top level.
// Bit-serial shared divider and shift-add multiplier with their sequencer.
// Depends on stf_pwm_pkg.
//
// Usage:
//   Input channel (in_*): one servo command per transfer - request type (angle in
//   1/64 degree or position in 1/16384 span), channel index, signed value.
//   Output channel (out_*): exactly one result per command - index status,
//   duty write flag, channel, duty compare value, pulse width, new target and
//   new smoothed angle. Invalid index gives an all-zero result.
//   Config port (cfg_*): APB-style, regs at 0x0 enable, 0x4 min pulse,
//   0x8 max pulse. pready is tied high, reads return the register value.
// Timing:
//   One command at a time. in_ready rises together with out_valid, so the next
//   command is taken as soon as the previous result is shown. With outputs
//   disabled the multiply and the angle and duty divides are skipped; an invalid
//   index goes straight to the result. The time is set by the shared restoring
//   divider (one quotient bit per cycle, for the 1/5 filter step, the angle scale
//   and the duty) and the shift-add multiply.
//   The input is taken again while a result still waits in the output
//   register; a stalled receiver only holds the next result in its final state.
// Reset: synchronous, active low. Registers return to enabled / 1050 / 1950 us
//   and all smoothed angles to 90 degrees.
module servo_target_filter_to_pwm_duty #(
  parameter int SERVO_COUNT = 5,
  parameter int DUTY_BITS   = 14,
  parameter int PERIOD_US   = 20000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [2:0]                         in_servo_index,
  input  logic signed [stf_pwm_pkg::CMD_W-1:0] in_command_value,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_index_ok,
  output logic                               out_duty_written,
  output logic [2:0]                         out_duty_channel,
  output logic [DUTY_BITS-1:0]               out_duty_value,
  output logic [stf_pwm_pkg::PULSE_W-1:0]    out_pulse_width_us,
  output logic [stf_pwm_pkg::ANGLE_W-1:0]    out_stored_target,
  output logic [stf_pwm_pkg::ANGLE_W-1:0]    out_filtered_target,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [stf_pwm_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [stf_pwm_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [stf_pwm_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import stf_pwm_pkg::*;

  // widths that follow from the parameters
  localparam int PW_W   = $clog2(PERIOD_US + 1);                    // pulse clipped to period
  localparam int DV_W   = (PW_W > ANGLE_W) ? PW_W : ANGLE_W;        // divisor / remainder
  localparam int QW     = (DUTY_BITS > PULSE_W) ? DUTY_BITS : PULSE_W; // quotient shifter
  localparam int NUM_W  = PW_W + DUTY_BITS;                         // duty numerator
  localparam int SIDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int HALF_PERIOD = PERIOD_US / 2;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_TGT  = 12'b0000_0000_0010,
    S_DIFF = 12'b0000_0000_0100,
    S_DIV5 = 12'b0000_0000_1000,
    S_FILT = 12'b0000_0001_0000,
    S_MUL  = 12'b0000_0010_0000,
    S_DIVA = 12'b0000_0100_0000,
    S_PW   = 12'b0000_1000_0000,
    S_RND  = 12'b0001_0000_0000,
    S_NUM  = 12'b0010_0000_0000,
    S_DIVB = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                en_r, en_nxt;
  logic [PULSE_W-1:0]  min_r, min_nxt;
  logic [PULSE_W-1:0]  max_r, max_nxt;
  logic [ANGLE_W-1:0]  smooth_r [SERVO_COUNT];
  logic                smooth_we;

  // working registers
  logic                     kind_r, kind_nxt;
  logic [2:0]               ch_r, ch_nxt;
  logic signed [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic                     ok_r, ok_nxt;
  logic                     wr_r, wr_nxt;
  logic [ANGLE_W-1:0]       tgt_r, tgt_nxt;
  logic                     neg_r, neg_nxt;
  logic [ANGLE_W-1:0]       filt_r, filt_nxt;
  logic [PULSE_W-1:0]       span_r, span_nxt;
  logic [PULSE_W-1:0]       pw_r, pw_nxt;
  logic [PW_W:0]            rnd_r, rnd_nxt;
  logic [DV_W-1:0]          rem_r, rem_nxt;
  logic [QW-1:0]            ql_r, ql_nxt;
  logic [PULSE_W-1:0]       mhi_r, mhi_nxt;
  logic [ANGLE_W-1:0]       mlo_r, mlo_nxt;

  // output registers
  logic                  out_ok_r, out_ok_nxt;
  logic                  out_wr_r, out_wr_nxt;
  logic [2:0]            out_ch_r, out_ch_nxt;
  logic [DUTY_BITS-1:0]  out_duty_r, out_duty_nxt;
  logic [PULSE_W-1:0]    out_pw_r, out_pw_nxt;
  logic [ANGLE_W-1:0]    out_tgt_r, out_tgt_nxt;
  logic [ANGLE_W-1:0]    out_filt_r, out_filt_nxt;

  // datapath terms
  logic                  in_xfer;
  logic                  cfg_wr;
  logic                  out_load;
  logic [SIDX_W-1:0]     cidx;
  logic [ANGLE_W-1:0]    smooth_cur;
  logic [PULSE_W-1:0]    vnorm;
  logic [19:0]           v45;
  logic [ANGLE_W-1:0]    tgt_c;
  logic [ANGLE_W:0]      sdiff;
  logic [ANGLE_W:0]      adiff;
  logic [ANGLE_W-1:0]    filt_c;
  logic [DV_W-1:0]       divisor;
  logic [DV_W:0]         div_sh;
  logic [DV_W+1:0]       div_sub;
  logic                  qbit;
  logic [PULSE_W:0]      mul_add;
  logic [PULSE_W:0]      pw_sum;
  logic [PW_W-1:0]       pwc;
  logic [NUM_W-1:0]      num;

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign cidx       = ch_r[SIDX_W-1:0];
  assign smooth_cur = smooth_r[cidx];

  // target: clamp, position scaled by 45/64
  always_comb begin
    if (cmd_r[CMD_W-1]) begin
      vnorm = '0;
    end else if (cmd_r[PULSE_W-1:0] > NORM_FULL) begin
      vnorm = NORM_FULL;
    end else begin
      vnorm = cmd_r[PULSE_W-1:0];
    end
    v45 = ({5'b0, vnorm} << 5) + ({5'b0, vnorm} << 3) + ({5'b0, vnorm} << 2) + {5'b0, vnorm};
    if (kind_r) begin
      tgt_c = v45[19:6];
    end else if (cmd_r[CMD_W-1]) begin
      tgt_c = '0;
    end else if (cmd_r[PULSE_W-1:0] > {1'b0, FULL_ANGLE}) begin
      tgt_c = FULL_ANGLE;
    end else begin
      tgt_c = cmd_r[ANGLE_W-1:0];
    end
  end

  assign sdiff  = {1'b0, tgt_r} - {1'b0, smooth_cur};
  assign adiff  = sdiff[ANGLE_W] ? (~sdiff + 1'b1) : sdiff;
  // quotient toward zero, applied with the sign of the difference
  assign filt_c = neg_r ? (smooth_cur - ql_r[ANGLE_W-1:0]) : (smooth_cur + ql_r[ANGLE_W-1:0]);

  // shared restoring divider, one quotient bit per cycle
  always_comb begin
    case (state_r)
      S_DIV5:  divisor = DV_W'(FILTER_DIV);
      S_DIVA:  divisor = DV_W'(FULL_ANGLE);
      default: divisor = DV_W'(PERIOD_US);
    endcase
  end
  assign div_sh  = {rem_r, ql_r[QW-1]};
  assign div_sub = {1'b0, div_sh} - {2'b0, divisor};
  assign qbit    = !div_sub[DV_W+1];

  // shift-add multiplier step: filtered angle times span
  assign mul_add = {1'b0, mhi_r} + (mlo_r[0] ? {1'b0, span_r} : '0);

  assign pw_sum = {1'b0, min_r} + {1'b0, ql_r[PULSE_W-1:0]};
  assign pwc    = ({1'b0, pw_r} > 16'(PERIOD_US)) ? PW_W'(PERIOD_US) : PW_W'(pw_r);
  // pw * (2^DUTY_BITS - 1) + PERIOD/2 as (pw << DUTY_BITS) + (PERIOD/2 - pw)
  assign num    = (NUM_W'(pwc) << DUTY_BITS) + {{(NUM_W-PW_W-1){rnd_r[PW_W]}}, rnd_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    ch_nxt    = ch_r;
    cmd_nxt   = cmd_r;
    ok_nxt    = ok_r;
    wr_nxt    = wr_r;
    tgt_nxt   = tgt_r;
    neg_nxt   = neg_r;
    filt_nxt  = filt_r;
    span_nxt  = span_r;
    pw_nxt    = pw_r;
    rnd_nxt   = rnd_r;
    rem_nxt   = rem_r;
    ql_nxt    = ql_r;
    mhi_nxt   = mhi_r;
    mlo_nxt   = mlo_r;
    smooth_we = 1'b0;

    unique case (state_r) inside
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt  = in_req_type;
          ch_nxt    = in_servo_index;
          cmd_nxt   = in_command_value;
          ok_nxt    = (4'(in_servo_index) < 4'(SERVO_COUNT));
          wr_nxt    = 1'b0;
          state_nxt = (4'(in_servo_index) < 4'(SERVO_COUNT)) ? S_TGT : S_DONE;
        end
      end
      S_TGT: begin
        tgt_nxt   = tgt_c;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        neg_nxt   = sdiff[ANGLE_W];
        rem_nxt   = '0;
        ql_nxt    = QW'(adiff[ANGLE_W-1:0]) << (QW - ANGLE_W);
        cnt_nxt   = 5'(ANGLE_W);
        state_nxt = S_DIV5;
      end
      S_DIV5, S_DIVA, S_DIVB: begin
        rem_nxt = qbit ? div_sub[DV_W-1:0] : div_sh[DV_W-1:0];
        ql_nxt  = {ql_r[QW-2:0], qbit};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          if (state_r == S_DIV5) begin
            state_nxt = S_FILT;
          end else if (state_r == S_DIVA) begin
            state_nxt = S_PW;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FILT: begin
        filt_nxt  = filt_c;
        smooth_we = 1'b1;
        span_nxt  = (max_r >= min_r) ? (max_r - min_r) : '0;
        mhi_nxt   = '0;
        mlo_nxt   = filt_c;
        cnt_nxt   = 5'(ANGLE_W);
        wr_nxt    = en_r;
        state_nxt = en_r ? S_MUL : S_DONE;
      end
      S_MUL: begin
        mhi_nxt = mul_add[PULSE_W:1];
        mlo_nxt = {mul_add[0], mlo_r[ANGLE_W-1:1]};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          // product bits above the quotient width seed the remainder
          rem_nxt   = DV_W'(mul_add[PULSE_W:2]);
          ql_nxt    = QW'({mul_add[1:0], mlo_r[ANGLE_W-1:1]}) << (QW - PULSE_W);
          cnt_nxt   = 5'(PULSE_W);
          state_nxt = S_DIVA;
        end
      end
      S_PW: begin
        pw_nxt    = (pw_sum > {1'b0, max_r}) ? max_r : pw_sum[PULSE_W-1:0];
        state_nxt = S_RND;
      end
      S_RND: begin
        rnd_nxt   = (PW_W+1)'(HALF_PERIOD) - {1'b0, pwc};
        state_nxt = S_NUM;
      end
      S_NUM: begin
        rem_nxt   = DV_W'(num[NUM_W-1:DUTY_BITS]);
        ql_nxt    = QW'(num[DUTY_BITS-1:0]) << (QW - DUTY_BITS);
        cnt_nxt   = 5'(DUTY_BITS);
        state_nxt = S_DIVB;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_ok_nxt    = out_ok_r;
    out_wr_nxt    = out_wr_r;
    out_ch_nxt    = out_ch_r;
    out_duty_nxt  = out_duty_r;
    out_pw_nxt    = out_pw_r;
    out_tgt_nxt   = out_tgt_r;
    out_filt_nxt  = out_filt_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = ok_r;
      out_wr_nxt    = ok_r && wr_r;
      out_ch_nxt    = (ok_r && wr_r) ? ch_r : '0;
      out_duty_nxt  = (ok_r && wr_r) ? ql_r[DUTY_BITS-1:0] : '0;
      out_pw_nxt    = (ok_r && wr_r) ? pw_r : '0;
      out_tgt_nxt   = ok_r ? tgt_r : '0;
      out_filt_nxt  = ok_r ? filt_r : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // configuration writes
  always_comb begin
    en_nxt  = en_r;
    min_nxt = min_r;
    max_nxt = max_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_ENABLE:    en_nxt  = cfg_pwdata[0];
        REG_MIN_PULSE: min_nxt = cfg_pwdata[PULSE_W-1:0];
        REG_MAX_PULSE: max_nxt = cfg_pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ENABLE:    cfg_prdata = {{(CFG_DW-1){1'b0}}, en_r};
      REG_MIN_PULSE: cfg_prdata = {{(CFG_DW-PULSE_W){1'b0}}, min_r};
      REG_MAX_PULSE: cfg_prdata = {{(CFG_DW-PULSE_W){1'b0}}, max_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b1;
      min_r       <= MIN_PULSE_RST;
      max_r       <= MAX_PULSE_RST;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        smooth_r[i] <= HOME_ANGLE;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      en_r        <= en_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      if (smooth_we) begin
        smooth_r[cidx] <= filt_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    ch_r       <= ch_nxt;
    cmd_r      <= cmd_nxt;
    ok_r       <= ok_nxt;
    wr_r       <= wr_nxt;
    tgt_r      <= tgt_nxt;
    neg_r      <= neg_nxt;
    filt_r     <= filt_nxt;
    span_r     <= span_nxt;
    pw_r       <= pw_nxt;
    rnd_r      <= rnd_nxt;
    rem_r      <= rem_nxt;
    ql_r       <= ql_nxt;
    mhi_r      <= mhi_nxt;
    mlo_r      <= mlo_nxt;
    out_ok_r   <= out_ok_nxt;
    out_wr_r   <= out_wr_nxt;
    out_ch_r   <= out_ch_nxt;
    out_duty_r <= out_duty_nxt;
    out_pw_r   <= out_pw_nxt;
    out_tgt_r  <= out_tgt_nxt;
    out_filt_r <= out_filt_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_index_ok        = out_ok_r;
  assign out_duty_written    = out_wr_r;
  assign out_duty_channel    = out_ch_r;
  assign out_duty_value      = out_duty_r;
  assign out_pulse_width_us  = out_pw_r;
  assign out_stored_target   = out_tgt_r;
  assign out_filtered_target = out_filt_r;

  // one command in flight
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("command taken while a previous one is in work");

  a_write_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wr_r) |-> out_ok_r)
    else $error("duty written for an invalid channel");

  a_pulse_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wr_r) |-> (out_pw_r <= max_r))
    else $error("pulse width above the maximum pulse");

  a_angles_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_filt_r <= FULL_ANGLE) && (out_tgt_r <= FULL_ANGLE)))
    else $error("angle beyond 180 degrees");

endmodule
